>>> sv/bmrtdr_pkg.sv
// Shared types and constants for the block Schur-complement update engine.
// Holds the command and response structs, opcode and status codes.
// No dependencies.
package bmrtdr_pkg;

  // Operand width of the term datapath and fraction bits of Q16.16.
  localparam int OPW       = 32;
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 64;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LIMIT = 2'd1;

  // Command codes; the two unused codes do nothing.
  typedef enum logic [2:0] {
    OP_LOAD_A   = 3'd0,
    OP_LOAD_R1  = 3'd1,
    OP_LOAD_R2  = 3'd2,
    OP_LOAD_D   = 3'd3,
    OP_UPDATE_A = 3'd4,
    OP_READ_A   = 3'd5
  } opcode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_LIMIT = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  // One command transaction.
  typedef struct packed {
    opcode_t            opcode;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] value;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic signed [31:0] result_value;
    status_t            status;
  } rsp_t;

endpackage

>>> sv/block_minus_rt_d_r_update.sv
// Top level of the block Schur-complement update engine: A, R1, R2 and D
// memories, the term pipeline, the accumulator and the command sequencer.
// Depends on bmrtdr_pkg.
//
//   Channel   Handshake             Payload
//   -------   -------------------   --------------------------------------
//   command   start, busy           cmd    (opcode, row, col, value)
//   result    done (strobe)         result (result_value, status)
//   config    cfg_valid, cfg_ready  cfg_index, cfg_data
//
// Loads complete in the cycle they are accepted; busy stays low.
// A read holds busy while in S_READ and returns its result from the result register.
// An update reads R1, R2 and D once per term for n = min(matrix_size, MAX_DIM) terms,
// then runs them through four pipeline stages, a subtract and a clamp.
// Limit violations answer the cycle after accept.
// Reset is synchronous; memory contents are undefined until loaded.
// The result strobe lasts one cycle; the receiver cannot stall it.
module block_minus_rt_d_r_update #(
  parameter int MAX_DIM    = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  bmrtdr_pkg::cmd_t                      cmd,
  output logic                                  done,
  output bmrtdr_pkg::rsp_t                      result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bmrtdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmrtdr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bmrtdr_pkg::*;

  localparam int ELEM_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int AW     = $clog2(MAX_DIM * MAX_DIM);
  localparam int DIW    = $clog2(MAX_DIM);
  localparam int KW     = $clog2(MAX_DIM + 1);

  localparam logic signed [ACC_W:0] ELEM_MAX =
    {{(ACC_W + 2 - ELEM_W){1'b0}}, {(ELEM_W - 1){1'b1}}};
  localparam logic signed [ACC_W:0] ELEM_MIN = ~ELEM_MAX;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_RUN   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_SUB   = 6'b010000,
    S_CLAMP = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] matrix_size;
  logic [CFG_DATA_W-1:0] active_limit;

  // Memories.
  logic [DATA_WIDTH-1:0] a_mem  [MAX_DIM*MAX_DIM];
  logic [DATA_WIDTH-1:0] r1_mem [MAX_DIM*MAX_DIM];
  logic [DATA_WIDTH-1:0] r2_mem [MAX_DIM*MAX_DIM];
  logic [DATA_WIDTH-1:0] d_mem  [MAX_DIM];
  logic [DATA_WIDTH-1:0] a_rd, r1_rd, r2_rd, d_rd;

  // Sequencer registers.
  logic [AW-1:0] upd_addr;
  logic [AW-1:0] r1_addr, r2_addr;
  logic [KW-1:0] k, n_eff;

  // Term pipeline.
  logic                     v1, v2, v3, v4;
  logic signed [2*OPW-1:0]  prod;
  logic signed [OPW-1:0]    r2_d;
  logic signed [2*OPW-1:0]  hh;
  logic signed [OPW+16:0]   ll;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_sat;
  logic signed [ACC_W:0]    diff;

  // Command decode.
  logic          accept, in_store, over_limit, issue;
  logic [AW-1:0] in_addr;
  logic [DATA_WIDTH-1:0] load_val;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_store  = (32'(cmd.row) < MAX_DIM) && (32'(cmd.col) < MAX_DIM);
  assign over_limit = ({1'b0, cmd.row} >= active_limit) ||
                      ({1'b0, cmd.col} >= active_limit) || !in_store;
  assign in_addr   = AW'(32'(cmd.row) * MAX_DIM + 32'(cmd.col));
  assign load_val  = DATA_WIDTH'($signed(cmd.value[ELEM_W-1:0]));
  assign issue     = (state == S_RUN) && (k != n_eff);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size  <= CFG_DATA_W'(32);
      active_limit <= CFG_DATA_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MATRIX_SIZE) matrix_size <= cfg_data;
      if (cfg_index == CFG_ACTIVE_LIMIT) active_limit <= cfg_data;
    end
  end

  // A memory: loads and update writeback share the write port.
  logic                  a_we, a_re;
  logic [AW-1:0]         a_waddr;
  logic [DATA_WIDTH-1:0] a_wdata;
  logic signed [ELEM_W-1:0] clamp_val;
  logic                     clamp_sat;

  assign a_re    = accept && (cmd.opcode == OP_UPDATE_A || cmd.opcode == OP_READ_A);
  assign a_we    = (accept && cmd.opcode == OP_LOAD_A && in_store) || (state == S_CLAMP);
  assign a_waddr = (state == S_CLAMP) ? upd_addr : in_addr;
  assign a_wdata = (state == S_CLAMP) ? DATA_WIDTH'(clamp_val) : load_val;

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_waddr] <= a_wdata;
    if (a_re) a_rd <= a_mem[in_addr];
  end

  // Factor and diagonal memories: loaded by commands, read by the sequencer.
  always_ff @(posedge clk) begin
    if (accept && cmd.opcode == OP_LOAD_R1 && in_store) r1_mem[in_addr] <= load_val;
    if (accept && cmd.opcode == OP_LOAD_R2 && in_store) r2_mem[in_addr] <= load_val;
    if (accept && cmd.opcode == OP_LOAD_D && 32'(cmd.row) < MAX_DIM) begin
      d_mem[DIW'(cmd.row)] <= load_val;
    end
    if (issue) begin
      r1_rd <= r1_mem[r1_addr];
      r2_rd <= r2_mem[r2_addr];
      d_rd  <= d_mem[k[DIW-1:0]];
    end
  end

  // Term pipeline: R1*D, then the split multiply by R2, then the term sum.
  always_ff @(posedge clk) begin
    prod <= (2*OPW)'($signed(r1_rd[ELEM_W-1:0])) *
            (2*OPW)'($signed(d_rd[ELEM_W-1:0]));
    r2_d <= OPW'($signed(r2_rd[ELEM_W-1:0]));
    hh   <= (2*OPW)'($signed(prod[2*OPW-1:2*FRAC_BITS])) * (2*OPW)'(r2_d);
    ll   <= (OPW+17)'($signed({1'b0, prod[2*FRAC_BITS-1:FRAC_BITS]})) *
            (OPW+17)'(r2_d);
    term <= hh + ACC_W'(ll >>> FRAC_BITS);
  end

  // Saturating accumulation of the terms.
  logic signed [ACC_W:0] acc_sum;
  assign acc_sum = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};

  always_ff @(posedge clk) begin
    if (accept) begin
      acc     <= '0;
      acc_sat <= 1'b0;
    end else if (v4) begin
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
        acc     <= acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        acc_sat <= 1'b1;
      end else begin
        acc <= acc_sum[ACC_W-1:0];
      end
    end
  end

  // Final subtract and clamp to the element range.
  always_ff @(posedge clk) begin
    if (state == S_SUB) begin
      diff <= (ACC_W + 1)'($signed(a_rd[ELEM_W-1:0])) - {acc[ACC_W-1], acc};
    end
  end

  always_comb begin
    clamp_sat = 1'b1;
    if (diff > ELEM_MAX) begin
      clamp_val = ELEM_MAX[ELEM_W-1:0];
    end else if (diff < ELEM_MIN) begin
      clamp_val = ELEM_MIN[ELEM_W-1:0];
    end else begin
      clamp_val = diff[ELEM_W-1:0];
      clamp_sat = 1'b0;
    end
  end

  // A result is due after a read, after the writeback, or for a rejected command.
  logic done_next;
  assign done_next = (state == S_READ) || (state == S_CLAMP) ||
                     (accept && cmd.opcode == OP_READ_A && !in_store) ||
                     (accept && cmd.opcode == OP_UPDATE_A && over_limit);

  // Command sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
    end else begin
      v1   <= issue;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= done_next;
      unique case (state)
        S_IDLE: begin
          if (accept && cmd.opcode == OP_READ_A) begin
            if (in_store) begin
              state <= S_READ;
            end else begin
              result <= '{result_value: '0, status: STATUS_LIMIT};
            end
          end else if (accept && cmd.opcode == OP_UPDATE_A) begin
            if (over_limit) begin
              result <= '{result_value: '0, status: STATUS_LIMIT};
            end else begin
              state    <= S_RUN;
              upd_addr <= in_addr;
              r1_addr  <= AW'(cmd.row);
              r2_addr  <= AW'(cmd.col);
              k        <= '0;
              n_eff    <= (32'(matrix_size) > MAX_DIM) ? KW'(MAX_DIM) : KW'(matrix_size);
            end
          end
        end
        S_READ: begin
          state  <= S_IDLE;
          result <= '{result_value: 32'($signed(a_rd[ELEM_W-1:0])), status: STATUS_OK};
        end
        S_RUN: begin
          if (issue) begin
            k       <= k + KW'(1);
            r1_addr <= r1_addr + AW'(MAX_DIM);
            r2_addr <= r2_addr + AW'(MAX_DIM);
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2 && !v3 && !v4) state <= S_SUB;
        end
        S_SUB: begin
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          state  <= S_IDLE;
          result <= '{result_value: 32'(clamp_val),
                      status: (clamp_sat || acc_sat) ? STATUS_SAT : STATUS_OK};
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result comes only from a read, a writeback or a rejected command.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_READ || state == S_CLAMP || (start && !busy)))
    else $error("result strobe without a source");

  // The subtract sees the accumulator only after every term has landed.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |-> (!v1 && !v2 && !v3 && !v4 && !issue))
    else $error("subtract started with terms in flight");

  // The block only turns busy on an accepted command.
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

endmodule
